// ===== rtl/core/emsu_pkg.sv =====
// Shared types and defaults for the edge midpoint subdivision unit.
// Holds the controller/datapath command and status structs and the field codes.
`default_nettype none

package emsu_pkg;

    localparam int DEF_VERTEX_SLOTS = 4096;
    localparam int DEF_EDGE_SLOTS   = 4096;
    localparam int DEF_COORD_BITS   = 32;

    localparam int IDX_W   = 12;
    localparam int OUT_C_W = 32;

    // Input command codes
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_SUBDIV = 2'd2;

    // Result kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_CORNER = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;

    typedef struct packed {
        logic       take_in;
        logic       clr_start;
        logic       clr_step;
        logic       load_vtx;
        logic       probe_start;
        logic       probe_next;
        logic [1:0] edge_sel;
        logic       clr_miss;
        logic       rec_miss;
        logic       rec_hit_mid;
        logic       sel_q;
        logic       cap_p;
        logic       insert;
        logic       emit_vtx;
        logic       emit_tri;
        logic [1:0] tri_sel;
        logic       emit_err;
        logic [1:0] err_code;
    } emsu_cmd_t;

    typedef struct packed {
        logic [1:0] cmd_code;
        logic       clear_done;
        logic       store_full;
        logic       corner_bad;
        logic       probe_hit;
        logic       probe_empty;
        logic       probe_exhausted;
        logic       overflow;
        logic       can_emit;
    } emsu_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/edge_midpoint_subdivision_unit.sv =====
// Edge midpoint subdivision unit: a triangle stream in, midpoint vertices and
// four sub-triangles per triangle out (or one error result). A start
// command and reset each run a clearing pass over the edge table of EDGE_SLOTS
// slots, during which no item is taken. A triangle probes each edge twice
// (count, then resolve) through one table read port; each new midpoint takes
// two vertex store reads, a write and a result, then the sub-triangles follow.
`default_nettype none

module edge_midpoint_subdivision_unit
    import emsu_pkg::*;
#(
    parameter int VERTEX_SLOTS = DEF_VERTEX_SLOTS,
    parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS,
    parameter int COORD_BITS   = DEF_COORD_BITS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // corner_a, corner_b, corner_c, coord_x, coord_y, coord_z, pad
    input  wire logic [135:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vertex_id, pos_x, pos_y, pos_z, tri_first, tri_second, tri_third,
    // error_code, pad
    output logic [151:0]      m_axis_tdata,
    // kind
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    emsu_cmd_t  cmd;
    emsu_stat_t stat;

    logic [IDX_W-1:0]   vid, t0, t1, t2;
    logic [OUT_C_W-1:0] px, py, pz;
    logic [1:0]         err;

    emsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    emsu_datapath #(
        .VERTEX_SLOTS (VERTEX_SLOTS),
        .EDGE_SLOTS   (EDGE_SLOTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_cmd    (s_axis_tuser),
        .in_a      (s_axis_tdata[11:0]),
        .in_b      (s_axis_tdata[23:12]),
        .in_c      (s_axis_tdata[35:24]),
        .in_x      (s_axis_tdata[67:36]),
        .in_y      (s_axis_tdata[99:68]),
        .in_z      (s_axis_tdata[131:100]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .out_vid   (vid),
        .out_x     (px),
        .out_y     (py),
        .out_z     (pz),
        .out_t0    (t0),
        .out_t1    (t1),
        .out_t2    (t2),
        .out_err   (err)
    );

    assign m_axis_tdata = {6'd0, err, t2, t1, t0, pz, py, px, vid};

endmodule

`default_nettype wire

// ===== rtl/core/emsu_ctrl.sv =====
// Sequencing state machine of the subdivision unit.
// Depends on emsu_pkg for the command and status structs.
`default_nettype none

module emsu_ctrl
    import emsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  emsu_stat_t      stat,
    output emsu_cmd_t       cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_PSTART = 4'd3;
    localparam logic [3:0] S_PREAD  = 4'd4;
    localparam logic [3:0] S_PCMP   = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_RDP    = 4'd7;
    localparam logic [3:0] S_RDQ    = 4'd8;
    localparam logic [3:0] S_INSERT = 4'd9;
    localparam logic [3:0] S_EMITV  = 4'd10;
    localparam logic [3:0] S_TRI    = 4'd11;
    localparam logic [3:0] S_ERR    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       phase2_reg, phase2_next;
    logic [1:0] edge_reg, edge_next;
    logic [1:0] tri_reg, tri_next;
    logic [1:0] err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            phase2_reg <= 1'b0;
            edge_reg   <= 2'd0;
            tri_reg    <= 2'd0;
            err_reg    <= ERR_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            phase2_reg <= phase2_next;
            edge_reg   <= edge_next;
            tri_reg    <= tri_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase2_next = phase2_reg;
        edge_next   = edge_reg;
        tri_next    = tri_reg;
        err_next    = err_reg;
        cmd         = '0;
        cmd.edge_sel = edge_reg;
        cmd.tri_sel  = tri_reg;
        cmd.err_code = err_reg;
        in_ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    cmd.clr_miss = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd_code)
                    CMD_START:
                    begin
                        cmd.clr_start = 1'b1;
                        state_next = S_CLEAR;
                    end
                    CMD_LOAD:
                    begin
                        if (stat.store_full)
                        begin
                            err_next = ERR_FULL;
                            state_next = S_ERR;
                        end
                        else
                        begin
                            cmd.load_vtx = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SUBDIV:
                    begin
                        if (stat.corner_bad)
                        begin
                            err_next = ERR_CORNER;
                            state_next = S_ERR;
                        end
                        else
                        begin
                            edge_next = 2'd0;
                            phase2_next = 1'b0;
                            state_next = S_PSTART;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_PSTART:
            begin
                cmd.probe_start = 1'b1;
                state_next = S_PREAD;
            end
            S_PREAD:
                state_next = S_PCMP;
            S_PCMP:
            begin
                if (stat.probe_hit)
                begin
                    cmd.rec_hit_mid = phase2_reg;
                    if (edge_reg == 2'd2)
                        state_next = phase2_reg ? S_TRI : S_CHECK;
                    else
                    begin
                        edge_next = edge_reg + 2'd1;
                        state_next = S_PSTART;
                    end
                end
                else if (stat.probe_empty || stat.probe_exhausted)
                begin
                    if (phase2_reg)
                        state_next = S_RDP;
                    else
                    begin
                        cmd.rec_miss = 1'b1;
                        if (edge_reg == 2'd2)
                            state_next = S_CHECK;
                        else
                        begin
                            edge_next = edge_reg + 2'd1;
                            state_next = S_PSTART;
                        end
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next = S_PREAD;
                end
            end
            S_CHECK:
            begin
                if (stat.overflow)
                begin
                    err_next = ERR_FULL;
                    state_next = S_ERR;
                end
                else
                begin
                    phase2_next = 1'b1;
                    edge_next = 2'd0;
                    tri_next = 2'd0;
                    state_next = S_PSTART;
                end
            end
            S_RDP:
                state_next = S_RDQ;
            S_RDQ:
            begin
                cmd.sel_q = 1'b1;
                cmd.cap_p = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_EMITV;
            end
            S_EMITV:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_vtx = 1'b1;
                    if (edge_reg == 2'd2)
                        state_next = S_TRI;
                    else
                    begin
                        edge_next = edge_reg + 2'd1;
                        state_next = S_PSTART;
                    end
                end
            end
            S_TRI:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_tri = 1'b1;
                    tri_next = tri_reg + 2'd1;
                    if (tri_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_err = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/emsu_datapath.sv =====
// Datapath: vertex store, hashed edge table, midpoint adder and result register.
// Depends on emsu_pkg; driven by emsu_ctrl through the command struct.
`default_nettype none

module emsu_datapath
    import emsu_pkg::*;
#(
    parameter int VERTEX_SLOTS = DEF_VERTEX_SLOTS,
    parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS,
    parameter int COORD_BITS   = DEF_COORD_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  emsu_cmd_t              cmd,
    output emsu_stat_t             stat,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [IDX_W-1:0]  in_a,
    input  wire logic [IDX_W-1:0]  in_b,
    input  wire logic [IDX_W-1:0]  in_c,
    input  wire logic [OUT_C_W-1:0] in_x,
    input  wire logic [OUT_C_W-1:0] in_y,
    input  wire logic [OUT_C_W-1:0] in_z,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   out_kind,
    output logic                   out_last,
    output logic [IDX_W-1:0]       out_vid,
    output logic [OUT_C_W-1:0]     out_x,
    output logic [OUT_C_W-1:0]     out_y,
    output logic [OUT_C_W-1:0]     out_z,
    output logic [IDX_W-1:0]       out_t0,
    output logic [IDX_W-1:0]       out_t1,
    output logic [IDX_W-1:0]       out_t2,
    output logic [1:0]             out_err
);

    localparam int VAW = $clog2(VERTEX_SLOTS);
    localparam int EAW = $clog2(EDGE_SLOTS);
    localparam int SW  = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int EW  = 1 + 2 * IDX_W + VAW;
    localparam int NCH = (2 * IDX_W + EAW - 1) / EAW;
    localparam logic [VAW+1:0] VS_LIM = (VAW+2)'(VERTEX_SLOTS);
    localparam logic [EAW+1:0] ES_LIM = (EAW+2)'(EDGE_SLOTS);
    localparam logic [EAW-1:0] E_LAST = EAW'(EDGE_SLOTS - 1);

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [VAW-1:0]   mid;
    } edge_ent_t;

    // Fold the 24-bit edge key into a table slot
    function automatic logic [EAW-1:0] slot_hash(input logic [2*IDX_W-1:0] key);
        logic [NCH*EAW-1:0] ext;
        logic [EAW-1:0]     h;
        logic [EAW:0]       hx;
        ext = (NCH*EAW)'(key);
        h = '0;
        for (int i = 0; i < NCH; i++)
            h = h ^ ext[i*EAW +: EAW];
        hx = {1'b0, h};
        if (hx >= (EAW+1)'(EDGE_SLOTS))
            hx = hx - (EAW+1)'(EDGE_SLOTS);
        return hx[EAW-1:0];
    endfunction

    logic [3*SW-1:0] store_mem [VERTEX_SLOTS];
    logic [EW-1:0]   edge_mem [EDGE_SLOTS];

    logic [1:0]         cmd_reg;
    logic [IDX_W-1:0]   a_reg, b_reg, c_reg;
    logic [3*SW-1:0]    xyz_reg;
    logic [VAW:0]       vc_reg;
    logic [EAW:0]       ec_reg;
    logic [EAW-1:0]     clr_idx_reg;
    logic [EAW-1:0]     probe_idx_reg;
    logic [EAW-1:0]     probe_cnt_reg;
    edge_ent_t          rd_edge_reg;
    logic [3*SW-1:0]    rd_store_reg;
    logic [3*SW-1:0]    p_data_reg;
    logic [2:0]         miss_reg;
    logic [VAW-1:0]     mid_reg [3];

    logic               ov_reg;
    logic               ok_kind_reg, ok_last_reg;
    logic [IDX_W-1:0]   o_vid_reg, o_t0_reg, o_t1_reg, o_t2_reg;
    logic [OUT_C_W-1:0] o_x_reg, o_y_reg, o_z_reg;
    logic [1:0]         o_err_reg;

    logic [IDX_W-1:0]   p_idx, q_idx, k_lo, k_hi;
    logic [IDX_W-1:0]   lo_e [3];
    logic [IDX_W-1:0]   hi_e [3];
    logic [1:0]         need;
    logic               dup1, dup2;
    logic [VAW-1:0]     st_addr;
    logic [SW:0]        sum_x, sum_y, sum_z;
    logic [3*SW-1:0]    mid_xyz;
    logic [VAW-1:0]     new_id;
    logic               emit_any;

    function automatic logic [VAW-1:0] to_vaddr(input logic [IDX_W-1:0] v);
        logic [VAW+IDX_W-1:0] t;
        t = {{VAW{1'b0}}, v};
        return t[VAW-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [VAW-1:0] v);
        logic [VAW+IDX_W-1:0] t;
        t = {{IDX_W{1'b0}}, v};
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [OUT_C_W-1:0] sx_out(input logic [SW-1:0] v);
        logic [OUT_C_W+SW-1:0] t;
        t = {{OUT_C_W{v[SW-1]}}, v};
        return t[OUT_C_W-1:0];
    endfunction

    // Edge endpoints and unordered keys
    always_comb
    begin
        case (cmd.edge_sel)
            2'd0:
            begin
                p_idx = a_reg;
                q_idx = b_reg;
            end
            2'd1:
            begin
                p_idx = b_reg;
                q_idx = c_reg;
            end
            default:
            begin
                p_idx = a_reg;
                q_idx = c_reg;
            end
        endcase
        k_lo = (p_idx < q_idx) ? p_idx : q_idx;
        k_hi = (p_idx < q_idx) ? q_idx : p_idx;
        lo_e[0] = (a_reg < b_reg) ? a_reg : b_reg;
        hi_e[0] = (a_reg < b_reg) ? b_reg : a_reg;
        lo_e[1] = (b_reg < c_reg) ? b_reg : c_reg;
        hi_e[1] = (b_reg < c_reg) ? c_reg : b_reg;
        lo_e[2] = (a_reg < c_reg) ? a_reg : c_reg;
        hi_e[2] = (a_reg < c_reg) ? c_reg : a_reg;
    end

    // Distinct missing edges: a repeated key counts once
    assign dup1 = miss_reg[0] && lo_e[1] == lo_e[0] && hi_e[1] == hi_e[0];
    assign dup2 = (miss_reg[0] && lo_e[2] == lo_e[0] && hi_e[2] == hi_e[0])
               || (miss_reg[1] && lo_e[2] == lo_e[1] && hi_e[2] == hi_e[1]);
    assign need = 2'(miss_reg[0]) + 2'(miss_reg[1] && !dup1) + 2'(miss_reg[2] && !dup2);

    assign st_addr = to_vaddr(cmd.sel_q ? q_idx : p_idx);
    assign new_id  = vc_reg[VAW-1:0];

    assign sum_x = {p_data_reg[SW-1], p_data_reg[SW-1:0]}
                 + {rd_store_reg[SW-1], rd_store_reg[SW-1:0]};
    assign sum_y = {p_data_reg[2*SW-1], p_data_reg[2*SW-1:SW]}
                 + {rd_store_reg[2*SW-1], rd_store_reg[2*SW-1:SW]};
    assign sum_z = {p_data_reg[3*SW-1], p_data_reg[3*SW-1:2*SW]}
                 + {rd_store_reg[3*SW-1], rd_store_reg[3*SW-1:2*SW]};
    assign mid_xyz = {sum_z[SW:1], sum_y[SW:1], sum_x[SW:1]};

    assign emit_any = cmd.emit_vtx || cmd.emit_tri || cmd.emit_err;

    always_comb
    begin
        stat.cmd_code        = cmd_reg;
        stat.clear_done      = clr_idx_reg == E_LAST;
        stat.store_full      = {1'b0, vc_reg} >= VS_LIM;
        stat.corner_bad      = {{(VAW+1){1'b0}}, a_reg} >= {{IDX_W{1'b0}}, vc_reg}
                            || {{(VAW+1){1'b0}}, b_reg} >= {{IDX_W{1'b0}}, vc_reg}
                            || {{(VAW+1){1'b0}}, c_reg} >= {{IDX_W{1'b0}}, vc_reg};
        stat.probe_hit       = rd_edge_reg.valid && rd_edge_reg.lo == k_lo
                            && rd_edge_reg.hi == k_hi;
        stat.probe_empty     = !rd_edge_reg.valid;
        stat.probe_exhausted = probe_cnt_reg == E_LAST;
        stat.overflow        = ({1'b0, vc_reg} + (VAW+2)'(need)) > VS_LIM
                            || ({1'b0, ec_reg} + (EAW+2)'(need)) > ES_LIM;
        stat.can_emit        = !ov_reg || out_ready;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_vtx)
            store_mem[vc_reg[VAW-1:0]] <= xyz_reg;
        else if (cmd.insert)
            store_mem[new_id] <= mid_xyz;
        rd_store_reg <= store_mem[st_addr];
        if (cmd.clr_step)
            edge_mem[clr_idx_reg] <= '0;
        else if (cmd.insert)
            edge_mem[probe_idx_reg] <= {1'b1, k_lo, k_hi, new_id};
        rd_edge_reg <= edge_ent_t'(edge_mem[probe_idx_reg]);
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            a_reg <= in_a;
            b_reg <= in_b;
            c_reg <= in_c;
            xyz_reg <= {in_z[SW-1:0], in_y[SW-1:0], in_x[SW-1:0]};
        end
        // hold the first endpoint, then the new midpoint here until its result goes out
        if (cmd.cap_p)
            p_data_reg <= rd_store_reg;
        else if (cmd.insert)
            p_data_reg <= mid_xyz;
        if (cmd.probe_start)
            probe_cnt_reg <= '0;
        else if (cmd.probe_next)
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        if (cmd.rec_hit_mid)
            mid_reg[cmd.edge_sel] <= rd_edge_reg.mid;
        else if (cmd.insert)
            mid_reg[cmd.edge_sel] <= new_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_START;
            vc_reg        <= '0;
            ec_reg        <= '0;
            clr_idx_reg   <= '0;
            probe_idx_reg <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            if (cmd.take_in)
                cmd_reg <= in_cmd;
            if (cmd.clr_start)
            begin
                vc_reg <= '0;
                ec_reg <= '0;
            end
            else if (cmd.load_vtx)
                vc_reg <= vc_reg + 1'b1;
            else if (cmd.insert)
            begin
                vc_reg <= vc_reg + 1'b1;
                ec_reg <= ec_reg + 1'b1;
            end
            if (cmd.clr_start)
                clr_idx_reg <= '0;
            else if (cmd.clr_step && clr_idx_reg != E_LAST)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.probe_start)
                probe_idx_reg <= slot_hash({k_hi, k_lo});
            else if (cmd.probe_next)
                probe_idx_reg <= (probe_idx_reg == E_LAST) ? '0 : probe_idx_reg + 1'b1;
            if (cmd.clr_miss)
                miss_reg <= '0;
            else if (cmd.rec_miss)
                miss_reg[cmd.edge_sel] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (emit_any)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            ok_kind_reg <= cmd.emit_vtx ? KIND_VERTEX : KIND_TRI;
            ok_last_reg <= cmd.emit_err || (cmd.emit_tri && cmd.tri_sel == 2'd3);
            o_vid_reg   <= cmd.emit_vtx ? to_idx(mid_reg[cmd.edge_sel]) : '0;
            o_x_reg     <= '0;
            o_y_reg     <= '0;
            o_z_reg     <= '0;
            o_t0_reg    <= '0;
            o_t1_reg    <= '0;
            o_t2_reg    <= '0;
            o_err_reg   <= cmd.emit_err ? cmd.err_code : ERR_NONE;
            if (cmd.emit_vtx)
            begin
                o_x_reg <= sx_out(p_data_reg[SW-1:0]);
                o_y_reg <= sx_out(p_data_reg[2*SW-1:SW]);
                o_z_reg <= sx_out(p_data_reg[3*SW-1:2*SW]);
            end
            if (cmd.emit_tri)
            begin
                case (cmd.tri_sel)
                    2'd0:
                    begin
                        o_t0_reg <= to_idx(mid_reg[0]);
                        o_t1_reg <= to_idx(mid_reg[1]);
                        o_t2_reg <= to_idx(mid_reg[2]);
                    end
                    2'd1:
                    begin
                        o_t0_reg <= a_reg;
                        o_t1_reg <= to_idx(mid_reg[0]);
                        o_t2_reg <= to_idx(mid_reg[2]);
                    end
                    2'd2:
                    begin
                        o_t0_reg <= b_reg;
                        o_t1_reg <= to_idx(mid_reg[0]);
                        o_t2_reg <= to_idx(mid_reg[1]);
                    end
                    default:
                    begin
                        o_t0_reg <= c_reg;
                        o_t1_reg <= to_idx(mid_reg[1]);
                        o_t2_reg <= to_idx(mid_reg[2]);
                    end
                endcase
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = ok_kind_reg;
    assign out_last  = ok_last_reg;
    assign out_vid   = o_vid_reg;
    assign out_x     = o_x_reg;
    assign out_y     = o_y_reg;
    assign out_z     = o_z_reg;
    assign out_t0    = o_t0_reg;
    assign out_t1    = o_t1_reg;
    assign out_t2    = o_t2_reg;
    assign out_err   = o_err_reg;

    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, vc_reg} <= VS_LIM)
        else $error("vertex count beyond store size");
    a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, ec_reg} <= ES_LIM)
        else $error("edge count beyond table size");
    a_ins_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> $past(stat.probe_empty, 3))
        else $error("edge inserted over an occupied slot");
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> (!ov_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== tb/tb_edge_midpoint_subdivision_unit.sv =====
// Self-checking testbench for edge_midpoint_subdivision_unit: stream driver, result
// monitor and an in-bench subdivision predictor. Depends on emsu_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_edge_midpoint_subdivision_unit;
    import emsu_pkg::*;

    localparam int SLOTS = DEF_VERTEX_SLOTS;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] ca, cb, cc;
        logic [31:0] x, y, z;
    } mesh_item_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] vid;
        logic [31:0] px, py, pz;
        logic [11:0] t0, t1, t2;
        logic        last;
        logic [1:0]  err;
    } mesh_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // corner_a, corner_b, corner_c, x, y, z, pad
    logic [1:0]   s_axis_tuser;   // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;   // vertex_id, pos xyz, tri verts, error_code, pad
    logic         m_axis_tuser;   // kind
    logic         m_axis_tlast;

    edge_midpoint_subdivision_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    mesh_item_t   pending_items[$];
    mesh_result_t expected_results[$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches = 0;
    int results_seen = 0;
    int triangles_sent;
    int cycles = 0;
    int gen_verts;

    // predictor state
    int          vtx_count = 0;
    logic [31:0] vtx_x[SLOTS];
    logic [31:0] vtx_y[SLOTS];
    logic [31:0] vtx_z[SLOTS];
    int          edge_mid[int];
    int          edge_count = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] midpoint(logic [31:0] p, logic [31:0] q);
        logic signed [32:0] s;
        s = $signed({p[31], p}) + $signed({q[31], q});
        return s[32:1];
    endfunction

    function automatic mesh_result_t fault_result(logic [1:0] code);
        mesh_result_t r;
        r = '{default: '0};
        r.kind = KIND_TRI;
        r.last = 1'b1;
        r.err = code;
        return r;
    endfunction

    task automatic predict_subdivision(mesh_item_t it);
        int c[3];
        int key[3];
        int mid[3];
        int need;
        int sub_tri[4][3];
        int p, q;
        bit seen;
        mesh_result_t r;
        c[0] = int'(it.ca);
        c[1] = int'(it.cb);
        c[2] = int'(it.cc);
        if (it.cmd == CMD_START)
        begin
            vtx_count = 0;
            edge_count = 0;
            edge_mid.delete();
            return;
        end
        if (it.cmd == CMD_LOAD)
        begin
            if (vtx_count >= SLOTS)
                expected_results = {expected_results, fault_result(ERR_FULL)};
            else
            begin
                vtx_x[vtx_count] = it.x;
                vtx_y[vtx_count] = it.y;
                vtx_z[vtx_count] = it.z;
                vtx_count++;
            end
            return;
        end
        if (it.cmd != CMD_SUBDIV)
            return;
        for (int k = 0; k < 3; k++)
        begin
            if (c[k] >= vtx_count)
            begin
                expected_results = {expected_results, fault_result(ERR_CORNER)};
                return;
            end
        end
        // edges ab, bc, ac keyed as (min,max)
        for (int e = 0; e < 3; e++)
        begin
            p = (e == 1) ? c[1] : c[0];
            q = (e == 0) ? c[1] : c[2];
            key[e] = (p < q) ? (p << 12) | q : (q << 12) | p;
        end
        need = 0;
        for (int e = 0; e < 3; e++)
        begin
            seen = edge_mid.exists(key[e]);
            for (int k = 0; k < e; k++)
                if (key[k] == key[e])
                    seen = 1;
            if (!seen)
                need++;
        end
        if (vtx_count + need > SLOTS || edge_count + need > DEF_EDGE_SLOTS)
        begin
            expected_results = {expected_results, fault_result(ERR_FULL)};
            return;
        end
        for (int e = 0; e < 3; e++)
        begin
            if (edge_mid.exists(key[e]))
                mid[e] = edge_mid[key[e]];
            else
            begin
                p = key[e] >> 12;
                q = key[e] & 12'hFFF;
                vtx_x[vtx_count] = midpoint(vtx_x[p], vtx_x[q]);
                vtx_y[vtx_count] = midpoint(vtx_y[p], vtx_y[q]);
                vtx_z[vtx_count] = midpoint(vtx_z[p], vtx_z[q]);
                r = '{default: '0};
                r.kind = KIND_VERTEX;
                r.vid = vtx_count[11:0];
                r.px = vtx_x[vtx_count];
                r.py = vtx_y[vtx_count];
                r.pz = vtx_z[vtx_count];
                r.err = ERR_NONE;
                expected_results = {expected_results, r};
                edge_mid[key[e]] = vtx_count;
                mid[e] = vtx_count;
                vtx_count++;
                edge_count++;
            end
        end
        sub_tri = '{'{mid[0], mid[1], mid[2]}, '{c[0], mid[0], mid[2]},
                    '{c[1], mid[0], mid[1]}, '{c[2], mid[1], mid[2]}};
        for (int k = 0; k < 4; k++)
        begin
            r = '{default: '0};
            r.kind = KIND_TRI;
            r.t0 = sub_tri[k][0][11:0];
            r.t1 = sub_tri[k][1][11:0];
            r.t2 = sub_tri[k][2][11:0];
            r.last = (k == 3);
            r.err = ERR_NONE;
            expected_results = {expected_results, r};
        end
    endtask

    // driver: advance to the next item only when the current transfer completes
    always @(posedge clk or negedge rst_n)
    begin
        mesh_item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= CMD_START;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.cmd;
                s_axis_tdata <= {4'b0, it.z, it.y, it.x, it.cc, it.cb, it.ca};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted input, check each result transfer
    always @(posedge clk)
    begin
        mesh_item_t it;
        mesh_result_t got, exp_r;
        if (rst_n)
        begin
            cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.cmd = s_axis_tuser;
                it.ca = s_axis_tdata[11:0];
                it.cb = s_axis_tdata[23:12];
                it.cc = s_axis_tdata[35:24];
                it.x = s_axis_tdata[67:36];
                it.y = s_axis_tdata[99:68];
                it.z = s_axis_tdata[131:100];
                predict_subdivision(it);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.last = m_axis_tlast;
                got.vid = m_axis_tdata[11:0];
                got.px = m_axis_tdata[43:12];
                got.py = m_axis_tdata[75:44];
                got.pz = m_axis_tdata[107:76];
                got.t0 = m_axis_tdata[119:108];
                got.t1 = m_axis_tdata[131:120];
                got.t2 = m_axis_tdata[143:132];
                got.err = m_axis_tdata[145:144];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got != exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d\n  expected %p\n  actual   %p",
                                     mismatches, exp_r, got);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_item(logic [1:0] cmd, int a, int b, int c,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        mesh_item_t it;
        it.cmd = cmd;
        it.ca = a[11:0];
        it.cb = b[11:0];
        it.cc = c[11:0];
        it.x = x;
        it.y = y;
        it.z = z;
        pending_items = {pending_items, it};
        if (cmd == CMD_START)
            gen_verts = 0;
        else if (cmd == CMD_LOAD)
            gen_verts++;
        else if (cmd == CMD_SUBDIV)
            triangles_sent++;
    endtask

    task automatic push_random_item();
        int r;
        int top;
        r = $urandom_range(99);
        top = (gen_verts > 0) ? gen_verts - 1 : 0;
        if (r < 4)
            push_item(CMD_START, 0, 0, 0, 0, 0, 0);
        else if (r < 35 || gen_verts < 3)
            push_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r < 90)
            push_item(CMD_SUBDIV, $urandom_range(top), $urandom_range(top),
                      $urandom_range(top), $urandom, $urandom, $urandom);
        else if (r < 96)
            push_item(CMD_SUBDIV, $urandom, $urandom, $urandom, 0, 0, 0);
        else
            push_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    endtask

    initial
    begin
        triangles_sent = 0;
        gen_verts = 0;
        send_idle_pct = 24;
        recv_idle_pct = 55;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, reversed and repeated edges, bad corner, unused code
        push_item(CMD_SUBDIV, 0, 0, 0, 0, 0, 0);
        push_item(CMD_LOAD, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_item(CMD_LOAD, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_item(CMD_LOAD, 0, 0, 0, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFE);
        push_item(CMD_LOAD, 4095, 4095, 4095, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003);
        push_item(CMD_SUBDIV, 0, 1, 2, 0, 0, 0);
        push_item(CMD_SUBDIV, 2, 1, 3, 0, 0, 0);
        push_item(CMD_SUBDIV, 1, 0, 3, 0, 0, 0);
        push_item(CMD_SUBDIV, 3, 3, 3, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 0, 2, 0, 0, 0);
        push_item(CMD_SUBDIV, 4095, 1, 2, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 4095, 2, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 1, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(2'd3, 4095, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(CMD_START, 0, 0, 0, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 1, 2, 0, 0, 0);
        for (int i = 0; i < 30; i++)
            push_random_item();
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 24;
        for (int i = 0; i < 30; i++)
            push_random_item();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 25; i++)
            push_random_item();
        // fresh mesh: shared and reversed edges, then a bad corner and a degenerate triangle
        push_item(CMD_START, 0, 0, 0, 0, 0, 0);
        push_item(CMD_LOAD, 0, 0, 0, 5, 6, 7);
        push_item(CMD_LOAD, 0, 0, 0, 32'hFFFF_FFFB, 9, 32'h8000_0001);
        push_item(CMD_LOAD, 0, 0, 0, 1, 2, 3);
        push_item(CMD_SUBDIV, 0, 1, 2, 0, 0, 0);
        push_item(CMD_SUBDIV, 2, 1, 0, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 1, 4093, 0, 0, 0);
        push_item(CMD_SUBDIV, 0, 0, 0, 0, 0, 0);
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d triangle commands and %0d checked results,", triangles_sent,
                 results_seen);
        $display("with bad corners, shared and reversed edges, stray codes and three idling mixes");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/emsu_pkg.sv
rtl/core/emsu_ctrl.sv
rtl/core/emsu_datapath.sv
rtl/core/edge_midpoint_subdivision_unit.sv
tb/tb_edge_midpoint_subdivision_unit.sv
